/* rtl/core/csbe_pkg.sv */
// Shared types and constants for the CAN serial bridge endpoint.
`timescale 1ns / 1ps

package csbe_pkg;

    localparam int RX_DEPTH_DEF   = 64;
    localparam int TX_DEPTH_DEF   = 16;
    localparam int UUID_BYTES_DEF = 6;

    localparam int MAX_FRAMES = 16;
    localparam int CNT_W      = $clog2(MAX_FRAMES + 1);

    localparam logic [15:0] TIMEOUT_RESET = 16'd30000;

    localparam logic [1:0] CMD_FRAME = 2'd0;
    localparam logic [1:0] CMD_TICK  = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;
    localparam logic [1:0] CMD_WRITE = 2'd3;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 64;

    localparam logic [1:0] REG_BASE_ID = 2'd0;
    localparam logic [1:0] REG_UUID    = 2'd1;
    localparam logic [1:0] REG_TIMEOUT = 2'd2;

    localparam logic OUT_KIND_FRAME  = 1'b0;
    localparam logic OUT_KIND_STATUS = 1'b1;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] can_id;
        logic [3:0]  frame_len;
        logic [63:0] frame_data;
        logic [7:0]  host_byte;
    } csbe_in_req_t;

    typedef struct packed {
        logic        out_kind;
        logic [16:0] tx_can_id;
        logic [3:0]  tx_len;
        logic [63:0] tx_data;
        logic        read_valid;
        logic [7:0]  read_byte;
        logic [5:0]  rx_available;
        logic        write_accepted;
        logic        overflow_seen;
        logic        last_item;
    } csbe_out_req_t;

endpackage

/* rtl/core/can_serial_bridge_endpoint_core.sv */
// CAN serial bridge endpoint: sequencer, ring buffers and register port.
//
//  channel | ports              | direction | request
//  --------+--------------------+-----------+---------------------------------
//  input   | s_valid/s_ready    | in        | s_req  (csbe_in_req_t)
//  result  | m_valid/m_ready    | out       | m_req  (csbe_out_req_t)
//  config  | psel/penable/...   | in        | APB write/read, 64-bit data
//
// One request at a time; s_ready only in idle. A tick or host read passes through
// idle, check, drain check, host step and status. A frame adds a decode step, an
// emit step per frame result and store steps for its bytes; each drained ring
// byte adds a drain check and a drain emit (registered ring read); an accepted
// write adds another drain check. m_ready low holds the sequencer at the next
// result. Reset is synchronous; the ring memories need no clearing pass.
`timescale 1ns / 1ps

module can_serial_bridge_endpoint_core #(
    parameter int RX_DEPTH   = csbe_pkg::RX_DEPTH_DEF,
    parameter int TX_DEPTH   = csbe_pkg::TX_DEPTH_DEF,
    parameter int UUID_BYTES = csbe_pkg::UUID_BYTES_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  csbe_pkg::csbe_in_req_t       s_req,
    output logic                         m_valid,
    input  logic                         m_ready,
    output csbe_pkg::csbe_out_req_t      m_req,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [csbe_pkg::ADDR_W-1:0]  paddr,
    input  logic [csbe_pkg::DATA_W-1:0]  pwdata,
    output logic [csbe_pkg::DATA_W-1:0]  prdata,
    output logic                         pready
);

    localparam int RX_AW = $clog2(RX_DEPTH);
    localparam int TX_AW = $clog2(TX_DEPTH);
    localparam int RX_CW = (RX_AW + 1 > 6) ? RX_AW + 1 : 6;
    localparam int CW    = csbe_pkg::CNT_W;

    localparam logic [3:0] S_IDLE       = 4'd0;
    localparam logic [3:0] S_CHECK      = 4'd1;
    localparam logic [3:0] S_FRAME      = 4'd2;
    localparam logic [3:0] S_EMIT       = 4'd3;
    localparam logic [3:0] S_STORE      = 4'd4;
    localparam logic [3:0] S_DRAIN_RD   = 4'd5;
    localparam logic [3:0] S_DRAIN_EMIT = 4'd6;
    localparam logic [3:0] S_HOST       = 4'd7;
    localparam logic [3:0] S_STATUS     = 4'd8;

    logic [3:0]       state_reg, state_next;
    logic [10:0]      base_id_reg, base_id_next;
    logic [47:0]      uuid_reg, uuid_next;
    logic [15:0]      timeout_reg, timeout_next;
    logic [15:0]      node_reg, node_next;
    logic             addr_valid_reg, addr_valid_next;
    logic [31:0]      now_reg, now_next;
    logic [31:0]      heard_reg, heard_next;
    logic [RX_AW-1:0] rx_rd_reg, rx_rd_next;
    logic [RX_AW-1:0] rx_wr_reg, rx_wr_next;
    logic [TX_AW-1:0] tx_rd_reg, tx_rd_next;
    logic [TX_AW-1:0] tx_wr_reg, tx_wr_next;
    logic             ovf_reg, ovf_next;
    logic             m_valid_reg, m_valid_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             second_reg, second_next;

    logic [1:0]       cmd_reg, cmd_next;
    logic [15:0]      can_id_reg, can_id_next;
    logic [3:0]       len_reg, len_next;
    logic [63:0]      data_reg, data_next;
    logic [7:0]       host_byte_reg, host_byte_next;
    logic [3:0]       idx_reg, idx_next;
    logic [16:0]      pend_id_reg, pend_id_next;
    logic [3:0]       pend_len_reg, pend_len_next;
    logic [63:0]      pend_data_reg, pend_data_next;
    logic             pend_store_reg, pend_store_next;
    logic             read_valid_reg, read_valid_next;
    logic [7:0]       read_byte_reg, read_byte_next;
    logic             wr_acc_reg, wr_acc_next;
    csbe_pkg::csbe_out_req_t m_req_reg, m_req_next;

    logic [7:0]       rx_mem_reg [RX_DEPTH];
    logic [7:0]       tx_mem_reg [TX_DEPTH];
    logic [7:0]       rx_rdata_reg;
    logic [7:0]       tx_rdata_reg;
    logic             rx_we;
    logic             tx_we;

    logic             cfg_we;
    logic [1:0]       cfg_idx;
    logic             out_free;
    logic [RX_AW-1:0] rx_wr_inc;
    logic [RX_AW-1:0] rx_rd_inc;
    logic [TX_AW-1:0] tx_wr_inc;
    logic [TX_AW-1:0] tx_rd_inc;
    logic [31:0]      silence;
    logic [15:0]      hb_id;
    logic [15:0]      asg_id;
    logic             uuid_match;
    logic [63:0]      announce;
    logic [RX_CW-1:0] rx_avail;
    logic [7:0]       store_byte;
    logic             tx_more;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[4:3];
    assign cfg_we  = psel && penable && pwrite;

    always_comb begin
        case (cfg_idx)
            csbe_pkg::REG_BASE_ID: prdata = {53'd0, base_id_reg};
            csbe_pkg::REG_UUID:    prdata = {16'd0, uuid_reg};
            csbe_pkg::REG_TIMEOUT: prdata = {48'd0, timeout_reg};
            default:               prdata = '0;
        endcase
    end

    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_req    = m_req_reg;
    assign out_free = !m_valid_reg || m_ready;

    assign rx_wr_inc = (rx_wr_reg == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_wr_reg + 1'b1;
    assign rx_rd_inc = (rx_rd_reg == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_rd_reg + 1'b1;
    assign tx_wr_inc = (tx_wr_reg == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_wr_reg + 1'b1;
    assign tx_rd_inc = (tx_rd_reg == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_rd_reg + 1'b1;

    assign silence    = now_reg - heard_reg;
    assign hb_id      = {5'd0, base_id_reg} + 16'd1;
    assign asg_id     = {5'd0, base_id_reg} + 16'd2;
    assign store_byte = data_reg[{idx_reg[2:0], 3'b000} +: 8];
    assign tx_more    = addr_valid_reg && (tx_rd_reg != tx_wr_reg)
                        && (cnt_reg < CW'(csbe_pkg::MAX_FRAMES));

    always_comb begin
        uuid_match = 1'b1;
        announce   = '0;
        for (int b = 0; b < UUID_BYTES; b++) begin
            if (uuid_reg[8*b +: 8] != data_reg[8*(b+2) +: 8]) begin
                uuid_match = 1'b0;
            end
            announce[8*b +: 8] = uuid_reg[8*b +: 8];
        end
    end

    always_comb begin
        if (rx_wr_reg >= rx_rd_reg) begin
            rx_avail = RX_CW'(rx_wr_reg) - RX_CW'(rx_rd_reg);
        end else begin
            rx_avail = RX_CW'(rx_wr_reg) + RX_CW'(RX_DEPTH) - RX_CW'(rx_rd_reg);
        end
    end

    always_comb begin
        state_next      = state_reg;
        base_id_next    = base_id_reg;
        uuid_next       = uuid_reg;
        timeout_next    = timeout_reg;
        node_next       = node_reg;
        addr_valid_next = addr_valid_reg;
        now_next        = now_reg;
        heard_next      = heard_reg;
        rx_rd_next      = rx_rd_reg;
        rx_wr_next      = rx_wr_reg;
        tx_rd_next      = tx_rd_reg;
        tx_wr_next      = tx_wr_reg;
        ovf_next        = ovf_reg;
        cnt_next        = cnt_reg;
        second_next     = second_reg;
        cmd_next        = cmd_reg;
        can_id_next     = can_id_reg;
        len_next        = len_reg;
        data_next       = data_reg;
        host_byte_next  = host_byte_reg;
        idx_next        = idx_reg;
        pend_id_next    = pend_id_reg;
        pend_len_next   = pend_len_reg;
        pend_data_next  = pend_data_reg;
        pend_store_next = pend_store_reg;
        read_valid_next = read_valid_reg;
        read_byte_next  = read_byte_reg;
        wr_acc_next     = wr_acc_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_req_next      = m_req_reg;
        rx_we           = 1'b0;
        tx_we           = 1'b0;

        if (cfg_we) begin
            case (cfg_idx)
                csbe_pkg::REG_BASE_ID: base_id_next = pwdata[10:0];
                csbe_pkg::REG_UUID:    uuid_next    = pwdata[47:0];
                csbe_pkg::REG_TIMEOUT: timeout_next = pwdata[15:0];
                default: ;
            endcase
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd_next        = s_req.command;
                    can_id_next     = s_req.can_id;
                    len_next        = (s_req.frame_len > 4'd8) ? 4'd8 : s_req.frame_len;
                    data_next       = s_req.frame_data;
                    host_byte_next  = s_req.host_byte;
                    cnt_next        = '0;
                    second_next     = 1'b0;
                    read_valid_next = 1'b0;
                    read_byte_next  = '0;
                    wr_acc_next     = 1'b0;
                    if (s_req.command == csbe_pkg::CMD_TICK) begin
                        now_next = now_reg + 32'd1;
                    end
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                if (silence > {16'd0, timeout_reg}) begin
                    addr_valid_next = 1'b0;
                end
                state_next = (cmd_reg == csbe_pkg::CMD_FRAME) ? S_FRAME : S_DRAIN_RD;
            end
            S_FRAME: begin
                state_next = S_DRAIN_RD;
                if (can_id_reg == hb_id) begin
                    heard_next = now_reg;
                    if (!addr_valid_reg || node_reg == data_reg[15:0]) begin
                        pend_id_next    = {6'd0, base_id_reg} + 17'd3;
                        pend_len_next   = 4'(UUID_BYTES);
                        pend_data_next  = announce;
                        pend_store_next = 1'b0;
                        state_next      = S_EMIT;
                    end
                end else if (can_id_reg == asg_id) begin
                    if (uuid_match) begin
                        node_next       = data_reg[15:0];
                        addr_valid_next = 1'b1;
                        heard_next      = now_reg;
                    end
                end else if (can_id_reg == node_reg) begin
                    idx_next = '0;
                    if (len_reg == 4'd0) begin
                        pend_id_next    = {1'b0, node_reg} + 17'd1;
                        pend_len_next   = 4'd0;
                        pend_data_next  = '0;
                        pend_store_next = 1'b1;
                        state_next      = S_EMIT;
                    end else begin
                        state_next = S_STORE;
                    end
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_req_next   = '0;
                    m_req_next.out_kind  = csbe_pkg::OUT_KIND_FRAME;
                    m_req_next.tx_can_id = pend_id_reg;
                    m_req_next.tx_len    = pend_len_reg;
                    m_req_next.tx_data   = pend_data_reg;
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = pend_store_reg ? S_STORE : S_DRAIN_RD;
                end
            end
            S_STORE: begin
                if (idx_reg == len_reg) begin
                    heard_next = now_reg;
                    state_next = S_DRAIN_RD;
                end else if (rx_wr_inc == rx_rd_reg) begin
                    ovf_next   = 1'b1;
                    state_next = S_DRAIN_RD;
                end else begin
                    rx_we      = 1'b1;
                    rx_wr_next = rx_wr_inc;
                    idx_next   = idx_reg + 1'b1;
                end
            end
            S_DRAIN_RD: begin
                if (tx_more) begin
                    state_next = S_DRAIN_EMIT;
                end else begin
                    state_next = second_reg ? S_STATUS : S_HOST;
                end
            end
            S_DRAIN_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_req_next   = '0;
                    m_req_next.out_kind  = csbe_pkg::OUT_KIND_FRAME;
                    m_req_next.tx_can_id = {1'b0, node_reg} + 17'd1;
                    m_req_next.tx_len    = 4'd1;
                    m_req_next.tx_data   = {56'd0, tx_rdata_reg};
                    cnt_next   = cnt_reg + 1'b1;
                    tx_rd_next = tx_rd_inc;
                    state_next = S_DRAIN_RD;
                end
            end
            S_HOST: begin
                state_next = S_STATUS;
                if (cmd_reg == csbe_pkg::CMD_READ) begin
                    if (rx_rd_reg != rx_wr_reg) begin
                        read_valid_next = 1'b1;
                        read_byte_next  = rx_rdata_reg;
                        rx_rd_next      = rx_rd_inc;
                    end
                end else if (cmd_reg == csbe_pkg::CMD_WRITE) begin
                    if (tx_wr_inc == tx_rd_reg) begin
                        ovf_next = 1'b1;
                    end else begin
                        tx_we       = 1'b1;
                        tx_wr_next  = tx_wr_inc;
                        wr_acc_next = 1'b1;
                        second_next = 1'b1;
                        state_next  = S_DRAIN_RD;
                    end
                end
            end
            S_STATUS: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_req_next   = '0;
                    m_req_next.out_kind       = csbe_pkg::OUT_KIND_STATUS;
                    m_req_next.read_valid     = read_valid_reg;
                    m_req_next.read_byte      = read_byte_reg;
                    m_req_next.rx_available   = rx_avail[5:0];
                    m_req_next.write_accepted = wr_acc_reg;
                    m_req_next.overflow_seen  = ovf_reg;
                    m_req_next.last_item      = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            base_id_reg    <= '0;
            uuid_reg       <= '0;
            timeout_reg    <= csbe_pkg::TIMEOUT_RESET;
            node_reg       <= '0;
            addr_valid_reg <= 1'b0;
            now_reg        <= '0;
            heard_reg      <= '0;
            rx_rd_reg      <= '0;
            rx_wr_reg      <= '0;
            tx_rd_reg      <= '0;
            tx_wr_reg      <= '0;
            ovf_reg        <= 1'b0;
            m_valid_reg    <= 1'b0;
            cnt_reg        <= '0;
            second_reg     <= 1'b0;
        end else begin
            state_reg      <= state_next;
            base_id_reg    <= base_id_next;
            uuid_reg       <= uuid_next;
            timeout_reg    <= timeout_next;
            node_reg       <= node_next;
            addr_valid_reg <= addr_valid_next;
            now_reg        <= now_next;
            heard_reg      <= heard_next;
            rx_rd_reg      <= rx_rd_next;
            rx_wr_reg      <= rx_wr_next;
            tx_rd_reg      <= tx_rd_next;
            tx_wr_reg      <= tx_wr_next;
            ovf_reg        <= ovf_next;
            m_valid_reg    <= m_valid_next;
            cnt_reg        <= cnt_next;
            second_reg     <= second_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg        <= cmd_next;
        can_id_reg     <= can_id_next;
        len_reg        <= len_next;
        data_reg       <= data_next;
        host_byte_reg  <= host_byte_next;
        idx_reg        <= idx_next;
        pend_id_reg    <= pend_id_next;
        pend_len_reg   <= pend_len_next;
        pend_data_reg  <= pend_data_next;
        pend_store_reg <= pend_store_next;
        read_valid_reg <= read_valid_next;
        read_byte_reg  <= read_byte_next;
        wr_acc_reg     <= wr_acc_next;
        m_req_reg      <= m_req_next;
    end

    // ring memories, registered read at the current read pointer
    always_ff @(posedge aclk) begin
        if (rx_we) begin
            rx_mem_reg[rx_wr_reg] <= store_byte;
        end
        rx_rdata_reg <= rx_mem_reg[rx_rd_reg];
    end

    always_ff @(posedge aclk) begin
        if (tx_we) begin
            tx_mem_reg[tx_wr_reg] <= host_byte_reg;
        end
        tx_rdata_reg <= tx_mem_reg[tx_rd_reg];
    end

endmodule

/* tb/sv/csbe_bridge_checker.sv */
// Checker for the CAN serial bridge endpoint: predicts results and compares them.
`timescale 1ns / 1ps

module csbe_bridge_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  csbe_pkg::csbe_in_req_t        s_req,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  csbe_pkg::csbe_out_req_t       m_req,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic                          pready,
    input  logic [csbe_pkg::ADDR_W-1:0]   paddr,
    input  logic [csbe_pkg::DATA_W-1:0]   pwdata,
    output int                            fail_count,
    output int                            results_due
);
    import csbe_pkg::*;

    logic [10:0]    base_id_r;
    logic [47:0]    uuid_r;
    logic [15:0]    timeout_r;

    logic [15:0]    node_id;
    logic           node_ok;
    logic [31:0]    now_ms;
    logic [31:0]    heard_ms;
    logic [7:0]     rx_mem [RX_DEPTH_DEF];
    logic [5:0]     rx_rd;
    logic [5:0]     rx_wr;
    logic [7:0]     tx_mem [TX_DEPTH_DEF];
    logic [3:0]     tx_rd;
    logic [3:0]     tx_wr;
    logic           ovf;

    csbe_out_req_t  due_results [$];
    int             step_frames;

    function void push_frame(logic [16:0] id, logic [3:0] len, logic [63:0] data);
        csbe_out_req_t item;
        item = '0;
        item.out_kind  = OUT_KIND_FRAME;
        item.tx_can_id = id;
        item.tx_len    = len;
        item.tx_data   = data;
        due_results.push_back(item);
        step_frames++;
    endfunction

    function void drain_tx_ring();
        if (!node_ok)
            return;
        while (tx_rd != tx_wr && step_frames < MAX_FRAMES) begin
            push_frame({1'b0, node_id} + 17'd1, 4'd1, {56'd0, tx_mem[tx_rd]});
            tx_rd = tx_rd + 4'd1;
        end
    endfunction

    function void take_can_frame(csbe_in_req_t r);
        logic [3:0] len;
        if (int'(r.can_id) == int'(base_id_r) + 1) begin
            heard_ms = now_ms;
            if ((!node_ok || node_id == r.frame_data[15:0]) && step_frames < MAX_FRAMES)
                push_frame({6'd0, base_id_r} + 17'd3, 4'(UUID_BYTES_DEF), {16'd0, uuid_r});
        end else if (int'(r.can_id) == int'(base_id_r) + 2) begin
            if (r.frame_data[63:16] == uuid_r) begin
                node_id  = r.frame_data[15:0];
                node_ok  = 1'b1;
                heard_ms = now_ms;
            end
        end else if (r.can_id == node_id) begin
            len = (r.frame_len > 4'd8) ? 4'd8 : r.frame_len;
            if (len == 4'd0 && step_frames < MAX_FRAMES)
                push_frame({1'b0, node_id} + 17'd1, 4'd0, 64'd0);
            for (int i = 0; i < int'(len); i++) begin
                if (rx_wr + 6'd1 == rx_rd) begin
                    ovf = 1'b1;
                    return;
                end
                rx_mem[rx_wr] = r.frame_data[8*i +: 8];
                rx_wr = rx_wr + 6'd1;
            end
            heard_ms = now_ms;
        end
    endfunction

    function void run_endpoint_step(csbe_in_req_t r);
        csbe_out_req_t status;
        logic [31:0]   quiet_ms;
        status = '0;
        step_frames = 0;
        if (r.command == CMD_TICK)
            now_ms = now_ms + 32'd1;
        quiet_ms = now_ms - heard_ms;
        if (quiet_ms > {16'd0, timeout_r})
            node_ok = 1'b0;
        if (r.command == CMD_FRAME)
            take_can_frame(r);
        drain_tx_ring();
        if (r.command == CMD_READ) begin
            if (rx_rd != rx_wr) begin
                status.read_valid = 1'b1;
                status.read_byte  = rx_mem[rx_rd];
                rx_rd = rx_rd + 6'd1;
            end
        end else if (r.command == CMD_WRITE) begin
            if (tx_wr + 4'd1 == tx_rd) begin
                ovf = 1'b1;
            end else begin
                tx_mem[tx_wr] = r.host_byte;
                tx_wr = tx_wr + 4'd1;
                status.write_accepted = 1'b1;
                drain_tx_ring();
            end
        end
        status.out_kind      = OUT_KIND_STATUS;
        status.rx_available  = rx_wr - rx_rd;
        status.overflow_seen = ovf;
        status.last_item     = 1'b1;
        due_results.push_back(status);
    endfunction

    function automatic int field_bad(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    function void check_result(csbe_out_req_t got);
        csbe_out_req_t want;
        if (due_results.size() == 0) begin
            $display("%0t ns: unexpected result, expected none, got 0x%0h", $time, got);
            fail_count++;
            return;
        end
        want = due_results.pop_front();
        fail_count += field_bad("out_kind", want.out_kind, got.out_kind);
        fail_count += field_bad("tx_can_id", want.tx_can_id, got.tx_can_id);
        fail_count += field_bad("tx_len", want.tx_len, got.tx_len);
        fail_count += field_bad("tx_data", want.tx_data, got.tx_data);
        fail_count += field_bad("read_valid", want.read_valid, got.read_valid);
        fail_count += field_bad("read_byte", want.read_byte, got.read_byte);
        fail_count += field_bad("rx_available", want.rx_available, got.rx_available);
        fail_count += field_bad("write_accepted", want.write_accepted, got.write_accepted);
        fail_count += field_bad("overflow_seen", want.overflow_seen, got.overflow_seen);
        fail_count += field_bad("last_item", want.last_item, got.last_item);
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            base_id_r  = '0;
            uuid_r     = '0;
            timeout_r  = TIMEOUT_RESET;
            node_id    = '0;
            node_ok    = 1'b0;
            now_ms     = '0;
            heard_ms   = '0;
            rx_rd      = '0;
            rx_wr      = '0;
            tx_rd      = '0;
            tx_wr      = '0;
            ovf        = 1'b0;
            fail_count = 0;
            due_results.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr)
                    {REG_BASE_ID, 3'b000}: base_id_r = pwdata[10:0];
                    {REG_UUID, 3'b000}:    uuid_r    = pwdata[47:0];
                    {REG_TIMEOUT, 3'b000}: timeout_r = pwdata[15:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                run_endpoint_step(s_req);
            if (m_valid && m_ready)
                check_result(m_req);
        end
        results_due = due_results.size();
    end

endmodule

/* tb/sv/tb_can_serial_bridge_endpoint_core.sv */
// Testbench top for the CAN serial bridge endpoint: stimulus, clock, reset and verdict.
`timescale 1ns / 1ps

module tb_can_serial_bridge_endpoint_core;
    import csbe_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int TAIL_CYCLES  = 40;
    localparam int PHASE_ITEMS  = 25;

    logic                 aclk    = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    csbe_in_req_t         s_req   = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    csbe_out_req_t        m_req;
    logic                 psel    = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite  = 1'b0;
    logic [ADDR_W-1:0]    paddr   = '0;
    logic [DATA_W-1:0]    pwdata  = '0;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;

    int                   fail_count;
    int                   results_due;
    int                   cycle_count = 0;
    bit                   gaps_on = 1'b1;

    logic [10:0]          base_r;
    logic [47:0]          uuid_r;
    logic [15:0]          node_r;

    can_serial_bridge_endpoint_core dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_req   (s_req),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_req   (m_req),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    csbe_bridge_checker bridge_chk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_req       (s_req),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_req       (m_req),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .fail_count  (fail_count),
        .results_due (results_due)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(negedge aclk) begin
        m_ready <= !gaps_on || ($urandom_range(0, 99) >= 10);
    end

    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic csbe_in_req_t noise_item();
        csbe_in_req_t r;
        r.command    = 2'($urandom);
        r.can_id     = 16'($urandom);
        r.frame_len  = 4'($urandom);
        r.frame_data = rand64();
        r.host_byte  = 8'($urandom);
        return r;
    endfunction

    function automatic csbe_in_req_t cmd_item(logic [1:0] cmd, logic [7:0] hb);
        csbe_in_req_t r;
        r = noise_item();
        r.command   = cmd;
        r.host_byte = hb;
        return r;
    endfunction

    function automatic csbe_in_req_t frame_item(logic [15:0] id, logic [3:0] len,
                                                logic [63:0] data);
        csbe_in_req_t r;
        r = noise_item();
        r.command    = CMD_FRAME;
        r.can_id     = id;
        r.frame_len  = len;
        r.frame_data = data;
        return r;
    endfunction

    function automatic csbe_in_req_t random_item();
        csbe_in_req_t r;
        int           pick;
        r = noise_item();
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            r.command = CMD_FRAME;
            if ($urandom_range(0, 7) != 0)
                r.can_id = node_r;
            r.frame_len = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15))
                                                      : 4'($urandom_range(0, 8));
        end else if (pick < 40) begin
            r.command = CMD_FRAME;
            r.can_id  = 16'(base_r) + 16'd1;
            if ($urandom_range(0, 1) != 0)
                r.frame_data[15:0] = node_r;
        end else if (pick < 47) begin
            r.command = CMD_FRAME;
            r.can_id  = 16'(base_r) + 16'd2;
            if ($urandom_range(0, 4) != 0)
                r.frame_data[63:16] = uuid_r;
            if (r.frame_data[63:16] == uuid_r)
                node_r = r.frame_data[15:0];
        end else if (pick < 52) begin
            r.command = CMD_FRAME;
        end else if (pick < 67) begin
            r.command = CMD_TICK;
        end else if (pick < 82) begin
            r.command = CMD_READ;
        end else begin
            r.command = CMD_WRITE;
        end
        return r;
    endfunction

    task automatic send_req(input csbe_in_req_t r);
        @(negedge aclk);
        while (gaps_on && $urandom_range(0, 99) < 10) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_req   <= r;
        do @(posedge aclk); while (!s_ready);
    endtask

    // hold off new requests until every result is back, then let the block go idle
    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (results_due != 0)
            @(negedge aclk);
        repeat (TAIL_CYCLES) @(negedge aclk);
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [63:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic configure(input logic [10:0] base, input logic [47:0] uuid,
                             input logic [15:0] timeout);
        base_r = base;
        uuid_r = uuid;
        apb_write(REG_BASE_ID, {53'd0, base});
        apb_write(REG_UUID, {16'd0, uuid});
        apb_write(REG_TIMEOUT, {48'd0, timeout});
    endtask

    initial begin
        int sent;
        base_r = '0;
        uuid_r = '0;
        node_r = '0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // defaults: node 0 held but not valid
        send_req(cmd_item(CMD_READ, 8'($urandom)));
        send_req(frame_item(16'd0, 4'd3, rand64()));
        send_req(frame_item(16'd0, 4'd0, rand64()));
        send_req(frame_item(16'd0, 4'd15, rand64()));
        send_req(cmd_item(CMD_READ, 8'($urandom)));
        send_req(cmd_item(CMD_READ, 8'($urandom)));
        send_req(frame_item(16'd1, 4'd0, 64'd0));

        settle();
        configure(11'h7FF, 48'hFFFF_FFFF_FFFF, 16'd0);
        node_r = 16'hFFFF;
        send_req(frame_item(16'd2049, 4'd2, {48'hFFFF_FFFF_FFFF, 16'hFFFF}));
        send_req(cmd_item(CMD_WRITE, 8'h00));
        send_req(cmd_item(CMD_WRITE, 8'hFF));
        send_req(frame_item(16'd2048, 4'd8, {48'($urandom), 16'hFFFF}));
        send_req(frame_item(16'd2048, 4'd8, {48'($urandom), 16'h1234}));
        send_req(cmd_item(CMD_TICK, 8'($urandom)));
        // ID lapsed: bytes pile up until the ring is full
        repeat (16) send_req(cmd_item(CMD_WRITE, 8'($urandom)));
        send_req(frame_item(16'd2049, 4'd8, {48'hFFFF_FFFF_FFFF, 16'hFFFF}));

        for (int phase = 0; phase < 3; phase++) begin
            settle();
            case (phase)
                0: begin
                    gaps_on = 1'b0;
                    configure(11'($urandom_range(1, 2046)), 48'(rand64()), 16'hFFFF);
                end
                1: begin
                    gaps_on = 1'b1;
                    configure(11'd0, 48'd0, 16'($urandom_range(2, 12)));
                end
                default: begin
                    configure(11'($urandom), 48'(rand64()), 16'($urandom_range(3, 20)));
                end
            endcase
            node_r = 16'($urandom);
            send_req(frame_item(16'(base_r) + 16'd2, 4'd8, {uuid_r, node_r}));
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                if ($urandom_range(0, 99) < 4) begin
                    repeat (9) send_req(frame_item(node_r, 4'd8, rand64()));
                    sent += 9;
                end else begin
                    send_req(random_item());
                    sent++;
                end
            end
        end

        settle();
        if (fail_count == 0 && results_due == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
